// File: design/mft_pkg.sv
`default_nettype none
package mft_pkg;

  localparam int unsigned TickW  = 8;
  localparam int unsigned PauseW = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ShiftW = 2 * ByteW;
  localparam int unsigned BitCntW = 5;
  localparam int unsigned FrameBits = ShiftW;

  localparam logic [TickW-1:0]  HalfBitTicksRst     = 8'd64;
  localparam logic [PauseW-1:0] PauseTransitionsRst = 10'd101;
  localparam logic [ByteW-1:0]  StartByteRst        = 8'hff;

  // configuration register indexes
  localparam logic [1:0] RegHalfBitTicks     = 2'd0;
  localparam logic [1:0] RegPauseTransitions = 2'd1;
  localparam logic [1:0] RegStartByte        = 2'd2;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = PauseW;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_PAUSE1     = 6'b000010,
    ST_WAIT_BIT   = 6'b000100,
    ST_FIRST_HALF = 6'b001000,
    ST_LAST_HALF  = 6'b010000,
    ST_PAUSE2     = 6'b100000
  } stage_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage
`default_nettype wire

// File: design/mft_core.sv
`default_nettype none
module mft_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [mft_pkg::CfgAddrW-1:0]    cfg_addr,
  input  wire [mft_pkg::CfgDataW-1:0]    cfg_wdata,
  input  wire                            acc,
  input  wire                            command,
  input  wire [mft_pkg::ByteW-1:0]       data_byte,
  output mft_pkg::result_t               result
);
  import mft_pkg::*;

  logic [TickW-1:0]   half_bit_ticks_r;
  logic [PauseW-1:0]  pause_transitions_r;
  logic [ByteW-1:0]   start_byte_r;

  logic [TickW-1:0]   tick_count_r, tick_count_nxt;
  logic               phase_r, phase_nxt;
  stage_t             stage_r, stage_nxt;
  logic [PauseW-1:0]  pause_count_r, pause_count_nxt;
  logic [ShiftW-1:0]  shift_r, shift_nxt;
  logic [BitCntW-1:0] bit_count_r, bit_count_nxt;
  logic               line_r, line_nxt;
  logic               done;

  logic [TickW:0]     tick_inc;
  logic               toggled;
  logic [PauseW-1:0]  pause_inc;
  logic               pause_over;
  logic [BitCntW-1:0] bit_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_ticks_r    <= HalfBitTicksRst;
      pause_transitions_r <= PauseTransitionsRst;
      start_byte_r        <= StartByteRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegHalfBitTicks:     half_bit_ticks_r    <= cfg_wdata[TickW-1:0];
        RegPauseTransitions: pause_transitions_r <= cfg_wdata[PauseW-1:0];
        RegStartByte:        start_byte_r        <= cfg_wdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_inc   = {1'b0, tick_count_r} + 1'b1;
    toggled    = (tick_inc >= {1'b0, half_bit_ticks_r});
    pause_inc  = pause_count_r + 1'b1;
    pause_over = (pause_inc >= pause_transitions_r);
    bit_inc    = bit_count_r + 1'b1;

    tick_count_nxt  = tick_count_r;
    phase_nxt       = phase_r;
    stage_nxt       = stage_r;
    pause_count_nxt = pause_count_r;
    shift_nxt       = shift_r;
    bit_count_nxt   = bit_count_r;
    line_nxt        = line_r;
    done            = 1'b0;

    if (command == CmdStart) begin
      if (stage_r == ST_IDLE) begin
        shift_nxt       = {start_byte_r, data_byte};
        bit_count_nxt   = '0;
        pause_count_nxt = '0;
        line_nxt        = 1'b0;
        stage_nxt       = ST_PAUSE1;
      end
    end else begin
      if (toggled) begin
        tick_count_nxt = '0;
        phase_nxt      = ~phase_r;
      end else begin
        tick_count_nxt = tick_inc[TickW-1:0];
      end

      unique case (stage_r)
        ST_IDLE: ;
        ST_PAUSE1: begin
          if (toggled) begin
            pause_count_nxt = pause_inc;
            if (pause_over) begin
              line_nxt  = 1'b1;
              stage_nxt = ST_WAIT_BIT;
              // pause may end right on the rising phase: first bit starts now
              if (phase_nxt) begin
                line_nxt  = shift_r[ShiftW-1];
                stage_nxt = ST_FIRST_HALF;
              end
            end
          end
        end
        ST_WAIT_BIT: begin
          if (phase_nxt) begin
            line_nxt  = shift_r[ShiftW-1];
            stage_nxt = ST_FIRST_HALF;
          end
        end
        ST_FIRST_HALF: begin
          if (!phase_nxt) begin
            line_nxt      = ~line_r;
            shift_nxt     = {shift_r[ShiftW-2:0], 1'b0};
            bit_count_nxt = bit_inc;
            stage_nxt     = (bit_inc >= BitCntW'(FrameBits)) ? ST_LAST_HALF : ST_WAIT_BIT;
          end
        end
        ST_LAST_HALF: begin
          if (phase_nxt) begin
            line_nxt        = 1'b0;
            pause_count_nxt = '0;
            stage_nxt       = ST_PAUSE2;
          end
        end
        ST_PAUSE2: begin
          if (toggled) begin
            pause_count_nxt = pause_inc;
            if (pause_over) begin
              line_nxt  = 1'b1;
              stage_nxt = ST_IDLE;
              done      = 1'b1;
            end
          end
        end
        default: stage_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      phase_r       <= 1'b0;
      stage_r       <= ST_IDLE;
      pause_count_r <= '0;
      shift_r       <= '0;
      bit_count_r   <= '0;
      line_r        <= 1'b1;
    end else if (acc) begin
      tick_count_r  <= tick_count_nxt;
      phase_r       <= phase_nxt;
      stage_r       <= stage_nxt;
      pause_count_r <= pause_count_nxt;
      shift_r       <= shift_nxt;
      bit_count_r   <= bit_count_nxt;
      line_r        <= line_nxt;
    end
  end

  assign result.line_level = line_nxt;
  assign result.busy_res   = (stage_nxt != ST_IDLE);
  assign result.frame_done = done;

endmodule
`default_nettype wire

// File: design/manchester_frame_transmitter_top.sv
`default_nettype none
// Manchester frame transmitter. Each input transaction is either a timer tick
// (in_tuser = 0) or a start-frame command (in_tuser = 1, data byte in
// in_tdata), and each one yields exactly one output transaction carrying the
// line level, a busy flag and, on tlast, the end-of-frame mark. One transaction
// is taken per clock while the skid register is empty; the frame state is
// updated and the result is registered in the accepting cycle. A two-entry
// output buffer (output register plus skid register) lets one input be taken
// while the output side is stalled; input ready then stays low until the skid register empties.
module manchester_frame_transmitter_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [mft_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire [mft_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [7:0]                    in_tdata,   // [7:0] data_byte
  input  wire                          in_tuser,   // [0] command
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [7:0]                   out_tdata,  // [0] line_level, [1] busy_res, zero pad
  output logic                         out_tlast   // frame_done
);
  import mft_pkg::*;

  logic    acc;
  result_t res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;

  assign in_tready = !skid_valid_r;
  assign acc       = in_tvalid && in_tready;

  mft_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .command   (in_tuser),
    .data_byte (in_tdata[ByteW-1:0]),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.busy_res, out_r.line_level};
  assign out_tlast  = out_r.frame_done;

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import mft_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int QuietLimit    = 2000;
  localparam int TicksPerPhase = 115;
  localparam int NumPhases     = 8;
  localparam int HoldCycles    = 60;

  // Predicts line level, busy and end-of-frame for every accepted transaction.
  class FrameScoreboard;
    logic [TickW-1:0]   half_ticks;
    logic [PauseW-1:0]  pause_len;
    logic [ByteW-1:0]   lead_byte;
    logic [TickW-1:0]   tick_cnt;
    logic               phase;
    stage_t             stage;
    logic [PauseW-1:0]  pause_cnt;
    logic [ShiftW-1:0]  shifter;
    logic [BitCntW-1:0] bits_sent;
    logic               line;
    result_t            expected_q[$];
    int                 errors;
    int                 checked;
    int                 frames_started;
    int                 frames_done;

    function new();
      half_ticks     = HalfBitTicksRst;
      pause_len      = PauseTransitionsRst;
      lead_byte      = StartByteRst;
      tick_cnt       = '0;
      phase          = 1'b0;
      stage          = ST_IDLE;
      pause_cnt      = '0;
      shifter        = '0;
      bits_sent      = '0;
      line           = 1'b1;
      errors         = 0;
      checked        = 0;
      frames_started = 0;
      frames_done    = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegHalfBitTicks:     half_ticks = val[TickW-1:0];
        RegPauseTransitions: pause_len = val;
        RegStartByte:        lead_byte = val[ByteW-1:0];
        default: ;
      endcase
    endfunction

    function bit pause_over();
      pause_cnt = pause_cnt + 1'b1;
      return pause_cnt >= pause_len;
    endfunction

    function void begin_bit();
      line  = shifter[ShiftW-1];
      stage = ST_FIRST_HALF;
    endfunction

    function void note_input(logic cmd, logic [ByteW-1:0] data);
      logic [TickW:0] nxt;
      bit             toggled;
      bit             done;
      result_t        r;
      toggled = 1'b0;
      done    = 1'b0;
      if (cmd == CmdStart) begin
        // a start while a frame is running changes nothing
        if (stage == ST_IDLE) begin
          shifter   = {lead_byte, data};
          bits_sent = '0;
          pause_cnt = '0;
          line      = 1'b0;
          stage     = ST_PAUSE1;
          frames_started++;
        end
      end else begin
        nxt = tick_cnt + 1'b1;
        if (nxt >= half_ticks) begin
          tick_cnt = '0;
          phase    = ~phase;
          toggled  = 1'b1;
        end else begin
          tick_cnt = nxt[TickW-1:0];
        end
        case (stage)
          ST_PAUSE1: begin
            if (toggled) begin
              if (pause_over()) begin
                line  = 1'b1;
                stage = ST_WAIT_BIT;
                // phase already high: first bit goes out on this tick
                if (phase) begin_bit();
              end
            end
          end
          ST_WAIT_BIT: begin
            if (phase) begin_bit();
          end
          ST_FIRST_HALF: begin
            if (!phase) begin
              line      = ~line;
              shifter   = shifter << 1;
              bits_sent = bits_sent + 1'b1;
              if (bits_sent >= FrameBits) stage = ST_LAST_HALF;
              else stage = ST_WAIT_BIT;
            end
          end
          ST_LAST_HALF: begin
            if (phase) begin
              line      = 1'b0;
              pause_cnt = '0;
              stage     = ST_PAUSE2;
            end
          end
          ST_PAUSE2: begin
            if (toggled) begin
              if (pause_over()) begin
                line  = 1'b1;
                stage = ST_IDLE;
                done  = 1'b1;
                frames_done++;
              end
            end
          end
          ST_IDLE: ;
          default: stage = ST_IDLE;
        endcase
      end
      r.line_level = line;
      r.busy_res   = (stage != ST_IDLE);
      r.frame_done = done;
      expected_q.push_back(r);
    endfunction

    function void check(logic [7:0] word, logic last);
      result_t e;
      if (expected_q.size() == 0) begin
        report("output transaction with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (word[0] !== e.line_level)
        report($sformatf("line_level got %b want %b", word[0], e.line_level));
      if (word[1] !== e.busy_res)
        report($sformatf("busy_res got %b want %b", word[1], e.busy_res));
      if (last !== e.frame_done)
        report($sformatf("frame_done got %b want %b", last, e.frame_done));
      if (word[7:2] !== 6'd0)
        report($sformatf("tdata pad bits got %b", word[7:2]));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;
  logic                out_tlast;

  FrameScoreboard sb;
  bit idle_on  = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;
  int cfg_phases = 0;

  manchester_frame_transmitter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(HalfPeriod) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transaction for %0d cycles", QuietLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task send_item(logic cmd, logic [7:0] data, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task put_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task set_config(logic [7:0] half, logic [9:0] pause, logic [7:0] lead);
    put_reg(RegHalfBitTicks, {2'b00, half});
    put_reg(RegPauseTransitions, pause);
    put_reg(RegStartByte, {2'b00, lead});
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  initial begin
    int         ticks;
    logic       cmd;
    logic [7:0] half;
    logic [9:0] pause;
    logic [7:0] lead;
    sb = new();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= RegHalfBitTicks;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= CmdTick;
    in_tdata  <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks at reset settings, then one frame started with zero timing registers
    repeat (3) send_item(CmdTick, 8'h00, 0);
    drain();
    set_config(8'd0, 10'd0, 8'h00);
    send_item(CmdStart, 8'hff, 0);
    send_item(CmdStart, 8'h00, 0);
    repeat (18) send_item(CmdTick, 8'($urandom_range(0, 255)), 0);
    drain();

    // settings change between phases, often in the middle of a frame
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          half = 8'd255;
          pause = 10'd1;
          lead = 8'hff;
        end
        1: begin
          half = 8'd0;
          pause = 10'd1023;
          lead = 8'($urandom_range(0, 255));
        end
        2: begin
          half = 8'd1;
          pause = 10'd2;
          lead = 8'($urandom_range(0, 255));
        end
        default: begin
          half = 8'($urandom_range(0, 3));
          pause = 10'($urandom_range(0, 4));
          lead = 8'($urandom_range(0, 255));
        end
      endcase
      set_config(half, pause, lead);
      idle_on = (ph % 3 != 1);
      if (ph == 4) hold_req = 1'b1;
      ticks = 0;
      while (ticks < TicksPerPhase) begin
        cmd = ($urandom_range(0, 99) < 8) ? CmdStart : CmdTick;
        send_item(cmd, 8'($urandom_range(0, 255)), pick_gap());
        if (cmd == CmdTick) ticks++;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results left over at end of run");
    $display("run: %0d transactions checked over %0d register settings", sb.checked,
             cfg_phases);
    $display("frames: %0d started, %0d completed", sb.frames_started, sb.frames_done);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
design/mft_pkg.sv
design/mft_core.sv
design/manchester_frame_transmitter_top.sv
test/testbench.sv
